### design/dflt_pkg.sv
`timescale 1ns / 1ps

package dflt_pkg;

   localparam int WORD_COUNT_BITS_DEFAULT = 16;
   localparam int LINE_COUNT_BITS_DEFAULT = 32;

   localparam int MAX_RESULTS = 4;
   localparam int SLOT_BITS   = $clog2(MAX_RESULTS);
   localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FORMFD  = 8'h0C;
   localparam logic [7:0] CH_RETURN  = 8'h0D;

   typedef enum logic [2:0] {
      KIND_CHAR,
      KIND_WORD_END,
      KIND_LINE_CLEAR,
      KIND_LINE_DONE,
      KIND_INPUT_END,
      KIND_OPEN_COMMENT
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_value;
      logic [15:0] word_count;
      logic [31:0] line_number;
   } result_type;

   // all events caused by one input transaction, slot 0 first
   typedef struct packed {
      logic [COUNT_BITS-1:0]       count;
      result_type [MAX_RESULTS-1:0] slot;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### design/dflt_front.sv
`timescale 1ns / 1ps

module dflt_front #(
   parameter int WORD_COUNT_BITS = dflt_pkg::WORD_COUNT_BITS_DEFAULT,
   parameter int LINE_COUNT_BITS = dflt_pkg::LINE_COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   input  logic                  queue_ready,
   output logic                  push,
   output dflt_pkg::bundle_type  push_data
);

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_SLASH,
      MODE_COLON,
      MODE_BLOCK,
      MODE_STAR,
      MODE_HASH
   } mode_type;

   typedef struct packed {
      mode_type                   mode;
      logic                       word_open;
      logic [WORD_COUNT_BITS-1:0] words;
      logic [LINE_COUNT_BITS-1:0] lines;
      dflt_pkg::bundle_type       bundle;
   } work_type;

   mode_type                   mode_ff;
   logic                       word_open_ff;
   logic [WORD_COUNT_BITS-1:0] words_ff;
   logic [LINE_COUNT_BITS-1:0] lines_ff;
   work_type                   work;
   logic                       accept;

   function automatic work_type emit(work_type w, dflt_pkg::kind_type k, logic [7:0] ch);
      work_type           r;
      dflt_pkg::result_type e;
      r = w;
      e.kind        = k;
      e.char_value  = (k == dflt_pkg::KIND_CHAR) ? ch : 8'h00;
      e.word_count  = (k == dflt_pkg::KIND_LINE_DONE) ? 16'(w.words) : 16'h0000;
      e.line_number = 32'(w.lines);
      if (w.bundle.count < dflt_pkg::COUNT_BITS'(dflt_pkg::MAX_RESULTS)) begin
         r.bundle.slot[w.bundle.count[dflt_pkg::SLOT_BITS-1:0]] = e;
         r.bundle.count = w.bundle.count + dflt_pkg::COUNT_BITS'(1);
      end
      return r;
   endfunction

   function automatic work_type plain(work_type w, logic [7:0] ch);
      work_type r;
      r = emit(w, dflt_pkg::KIND_CHAR, ch);
      r.word_open = 1'b1;
      return r;
   endfunction

   function automatic work_type close_word(work_type w);
      work_type r;
      r = w;
      if (w.word_open) begin
         r = emit(w, dflt_pkg::KIND_WORD_END, 8'h00);
         if (r.words != '1) r.words = r.words + WORD_COUNT_BITS'(1);
         r.word_open = 1'b0;
      end
      return r;
   endfunction

   function automatic work_type count_line(work_type w);
      work_type r;
      r = w;
      if (w.lines != '1) r.lines = w.lines + LINE_COUNT_BITS'(1);
      return r;
   endfunction

   function automatic work_type finish_line(work_type w);
      work_type r;
      r = close_word(w);
      r = count_line(r);
      r = emit(r, dflt_pkg::KIND_LINE_DONE, 8'h00);
      r.words     = '0;
      r.word_open = 1'b0;
      return r;
   endfunction

   function automatic work_type normal_byte(work_type w, logic [7:0] c);
      work_type r;
      r = w;
      case (c)
         dflt_pkg::CH_NEWLINE: r = finish_line(w);
         dflt_pkg::CH_SLASH:   r.mode = MODE_SLASH;
         dflt_pkg::CH_HASH:    r.mode = MODE_HASH;
         dflt_pkg::CH_COLON:   r.mode = MODE_COLON;
         dflt_pkg::CH_SEMI:    r = close_word(w);
         dflt_pkg::CH_LBRACE, dflt_pkg::CH_RBRACE: begin
            r = close_word(w);
            r = plain(r, c);
            r = close_word(r);
         end
         default:              r = plain(w, c);
      endcase
      return r;
   endfunction

   always_comb begin
      work.mode      = mode_ff;
      work.word_open = word_open_ff;
      work.words     = words_ff;
      work.lines     = lines_ff;
      work.bundle    = '0;
      if (req_tuser) begin
         case (mode_ff)
            MODE_HASH: begin
               work = finish_line(work);
               work = emit(work, dflt_pkg::KIND_INPUT_END, 8'h00);
            end
            MODE_BLOCK, MODE_STAR: work = emit(work, dflt_pkg::KIND_OPEN_COMMENT, 8'h00);
            default:               work = emit(work, dflt_pkg::KIND_INPUT_END, 8'h00);
         endcase
         work.mode      = MODE_NORMAL;
         work.words     = '0;
         work.word_open = 1'b0;
      end else begin
         case (mode_ff)
            MODE_SLASH: begin
               if (req_tdata == dflt_pkg::CH_STAR) begin
                  work.mode = MODE_BLOCK;
               end else begin
                  work.mode = MODE_NORMAL;
                  work = plain(work, dflt_pkg::CH_SLASH);
                  work = normal_byte(work, req_tdata);
               end
            end
            MODE_COLON: begin
               work.mode = MODE_NORMAL;
               if (req_tdata inside {dflt_pkg::CH_SPACE, dflt_pkg::CH_TAB, dflt_pkg::CH_NEWLINE,
                                     dflt_pkg::CH_VTAB, dflt_pkg::CH_FORMFD,
                                     dflt_pkg::CH_RETURN}) begin
                  work = emit(work, dflt_pkg::KIND_LINE_CLEAR, 8'h00);
                  work.words     = '0;
                  work.word_open = 1'b0;
               end else begin
                  work = plain(work, dflt_pkg::CH_COLON);
               end
               work = normal_byte(work, req_tdata);
            end
            MODE_BLOCK: begin
               if (req_tdata == dflt_pkg::CH_STAR) work.mode = MODE_STAR;
               else if (req_tdata == dflt_pkg::CH_NEWLINE) work = count_line(work);
            end
            MODE_STAR: begin
               if (req_tdata == dflt_pkg::CH_SLASH) begin
                  work.mode = MODE_NORMAL;
               end else if (req_tdata != dflt_pkg::CH_STAR) begin
                  work.mode = MODE_BLOCK;
                  if (req_tdata == dflt_pkg::CH_NEWLINE) work = count_line(work);
               end
            end
            MODE_HASH: begin
               if (req_tdata == dflt_pkg::CH_NEWLINE) begin
                  work.mode = MODE_NORMAL;
                  work = finish_line(work);
               end
            end
            default: begin
               work.mode = MODE_NORMAL;
               work = normal_byte(work, req_tdata);
            end
         endcase
      end
   end

   assign accept    = req_tvalid && queue_ready;
   // a transaction that causes no event updates state only
   assign push      = accept && (work.bundle.count != '0);
   assign push_data = work.bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         word_open_ff <= 1'b0;
         words_ff     <= '0;
         lines_ff     <= '0;
      end else if (accept) begin
         mode_ff      <= work.mode;
         word_open_ff <= work.word_open;
         words_ff     <= work.words;
         lines_ff     <= work.lines;
      end
   end

endmodule

### design/dflt_queue.sv
`timescale 1ns / 1ps

module dflt_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dflt_pkg::bundle_type       push_data,
   input  logic                       pop,
   output dflt_pkg::bundle_type       head,
   output dflt_pkg::queue_status_type status
);

   localparam int DEPTH = dflt_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);

   dflt_pkg::bundle_type mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) count_in = count_ff + (PTR_BITS + 1)'(1);
      else if (pop && !push) count_in = count_ff - (PTR_BITS + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (PTR_BITS + 1)'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

### design/dflt_back.sv
`timescale 1ns / 1ps

module dflt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dflt_pkg::bundle_type       head,
   input  dflt_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [55:0]                rsp_tdata,
   output logic [2:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   logic [dflt_pkg::SLOT_BITS-1:0] idx_ff, idx_in;
   logic                           valid_ff, valid_in;
   dflt_pkg::result_type           result_ff;
   logic                           last_ff;
   logic                           load;
   logic                           is_last;

   // advance whenever the queue holds an event and the output register is free or being drained
   assign load    = !status.empty && (!valid_ff || rsp_tready);
   assign is_last = (dflt_pkg::COUNT_BITS'(idx_ff) + dflt_pkg::COUNT_BITS'(1)) == head.count;
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = is_last ? '0 : idx_ff + dflt_pkg::SLOT_BITS'(1);
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= head.slot[idx_ff];
         last_ff   <= is_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {result_ff.line_number, result_ff.word_count, result_ff.char_value};
   assign rsp_tuser  = result_ff.kind;
   assign rsp_tlast  = last_ff;

endmodule

### design/data_file_line_tokenizer.sv
`timescale 1ns / 1ps
// An accepted input transaction's first result is written to the event queue, then loaded
// into the output register, from which it is valid on rsp.
// Throughput: one input byte per cycle while the event queue is not full, and one result per
// cycle while rsp_tready is high; an item with k results is sent one result at a time, and a
// four-entry event queue absorbs bursts. Reset (synchronous, active high) clears scan mode,
// word and line counters, the queue and the output valid.
module data_file_line_tokenizer #(
   parameter int WORD_COUNT_BITS = dflt_pkg::WORD_COUNT_BITS_DEFAULT,
   parameter int LINE_COUNT_BITS = dflt_pkg::LINE_COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] char_value, [23:8] word_count, [55:24] line_number
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast
);

   dflt_pkg::bundle_type       push_data;
   dflt_pkg::bundle_type       head;
   dflt_pkg::queue_status_type status;
   logic                       push;
   logic                       pop;

   assign req_tready = !status.full;

   dflt_front #(
      .WORD_COUNT_BITS(WORD_COUNT_BITS),
      .LINE_COUNT_BITS(LINE_COUNT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_ready (req_tready),
      .push        (push),
      .push_data   (push_data)
   );

   dflt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (status)
   );

   dflt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != dflt_pkg::KIND_CHAR) |-> (rsp_tdata[7:0] == 8'h00))
      else $error("character value on a non-character event");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != dflt_pkg::KIND_LINE_DONE) |-> (rsp_tdata[23:8] == 16'h0000))
      else $error("word count on an event other than line done");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == dflt_pkg::KIND_INPUT_END ||
                      rsp_tuser == dflt_pkg::KIND_OPEN_COMMENT)) |-> rsp_tlast)
      else $error("end of input event is not the last of its run");

   assert property (@(posedge clock) disable iff (reset)
      (push && status.full) |-> pop)
      else $error("event queue overflow");
`endif

endmodule

### tb/token_event_checker.sv
`timescale 1ns / 1ps

module token_event_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          events_outstanding,
   output int          mismatch_count
);

   typedef enum logic [2:0] {
      SCAN_NORMAL,
      SCAN_SLASH,
      SCAN_COLON,
      SCAN_BLOCK,
      SCAN_STAR,
      SCAN_HASH
   } scan_type;

   typedef struct {
      dflt_pkg::kind_type kind;
      logic [7:0]         char_value;
      logic [15:0]        word_count;
      logic [31:0]        line_number;
      logic               last;
   } token_event_type;

   scan_type    scan;
   logic        word_open;
   logic [15:0] line_words;
   logic [31:0] line_count;

   token_event_type step_events[$];
   token_event_type expected_events[$];
   int              errors = 0;

   function automatic void add_event(dflt_pkg::kind_type kind, logic [7:0] ch);
      token_event_type e;
      e.kind        = kind;
      e.char_value  = (kind == dflt_pkg::KIND_CHAR) ? ch : 8'h00;
      e.word_count  = (kind == dflt_pkg::KIND_LINE_DONE) ? line_words : 16'h0000;
      e.line_number = line_count;
      e.last        = 1'b0;
      step_events.push_back(e);
   endfunction

   function automatic void emit_char(logic [7:0] ch);
      add_event(dflt_pkg::KIND_CHAR, ch);
      word_open = 1'b1;
   endfunction

   function automatic void end_word();
      if (word_open) begin
         add_event(dflt_pkg::KIND_WORD_END, 8'h00);
         if (line_words != 16'hFFFF) line_words = line_words + 16'd1;
         word_open = 1'b0;
      end
   endfunction

   function automatic void bump_line();
      if (line_count != 32'hFFFF_FFFF) line_count = line_count + 32'd1;
   endfunction

   function automatic void end_line();
      end_word();
      bump_line();
      add_event(dflt_pkg::KIND_LINE_DONE, 8'h00);
      line_words = 16'h0000;
      word_open  = 1'b0;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == dflt_pkg::CH_SPACE || c == dflt_pkg::CH_TAB || c == dflt_pkg::CH_NEWLINE ||
             c == dflt_pkg::CH_VTAB || c == dflt_pkg::CH_FORMFD || c == dflt_pkg::CH_RETURN;
   endfunction

   function automatic void plain_byte(logic [7:0] c);
      case (c)
         dflt_pkg::CH_NEWLINE: end_line();
         dflt_pkg::CH_SLASH:   scan = SCAN_SLASH;
         dflt_pkg::CH_HASH:    scan = SCAN_HASH;
         dflt_pkg::CH_COLON:   scan = SCAN_COLON;
         dflt_pkg::CH_SEMI:    end_word();
         dflt_pkg::CH_LBRACE, dflt_pkg::CH_RBRACE: begin
            end_word();
            emit_char(c);
            end_word();
         end
         default:              emit_char(c);
      endcase
   endfunction

   function automatic void predict_events(logic [7:0] c, logic eoi);
      step_events.delete();
      if (eoi) begin
         if (scan == SCAN_HASH) begin
            end_line();
            add_event(dflt_pkg::KIND_INPUT_END, 8'h00);
         end else if (scan == SCAN_BLOCK || scan == SCAN_STAR) begin
            add_event(dflt_pkg::KIND_OPEN_COMMENT, 8'h00);
         end else begin
            add_event(dflt_pkg::KIND_INPUT_END, 8'h00);
         end
         scan       = SCAN_NORMAL;
         line_words = 16'h0000;
         word_open  = 1'b0;
      end else begin
         case (scan)
            SCAN_SLASH: begin
               if (c == dflt_pkg::CH_STAR) begin
                  scan = SCAN_BLOCK;
               end else begin
                  scan = SCAN_NORMAL;
                  emit_char(dflt_pkg::CH_SLASH);
                  plain_byte(c);
               end
            end
            SCAN_COLON: begin
               scan = SCAN_NORMAL;
               if (is_space(c)) begin
                  add_event(dflt_pkg::KIND_LINE_CLEAR, 8'h00);
                  line_words = 16'h0000;
                  word_open  = 1'b0;
               end else begin
                  emit_char(dflt_pkg::CH_COLON);
               end
               plain_byte(c);
            end
            SCAN_BLOCK: begin
               if (c == dflt_pkg::CH_STAR) scan = SCAN_STAR;
               else if (c == dflt_pkg::CH_NEWLINE) bump_line();
            end
            SCAN_STAR: begin
               if (c == dflt_pkg::CH_SLASH) begin
                  scan = SCAN_NORMAL;
               end else if (c != dflt_pkg::CH_STAR) begin
                  scan = SCAN_BLOCK;
                  if (c == dflt_pkg::CH_NEWLINE) bump_line();
               end
            end
            SCAN_HASH: begin
               if (c == dflt_pkg::CH_NEWLINE) begin
                  scan = SCAN_NORMAL;
                  end_line();
               end
            end
            default: plain_byte(c);
         endcase
      end
      if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
      foreach (step_events[i]) expected_events.push_back(step_events[i]);
   endfunction

   function automatic void check_event();
      token_event_type e;
      if (expected_events.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: unexpected result kind %0d data %h last %0b", $realtime,
                     rsp_tuser, rsp_tdata, rsp_tlast);
         return;
      end
      e = expected_events.pop_front();
      if (rsp_tuser !== e.kind || rsp_tdata[7:0] !== e.char_value ||
          rsp_tdata[23:8] !== e.word_count || rsp_tdata[55:24] !== e.line_number ||
          rsp_tlast !== e.last) begin
         errors++;
         if (errors <= 10)
            $display({"%0t: mismatch kind %0d/%0d char %h/%h words %0d/%0d ",
                      "line %0d/%0d last %0b/%0b"},
                     $realtime, e.kind, rsp_tuser, e.char_value, rsp_tdata[7:0],
                     e.word_count, rsp_tdata[23:8], e.line_number, rsp_tdata[55:24],
                     e.last, rsp_tlast);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         scan       = SCAN_NORMAL;
         word_open  = 1'b0;
         line_words = 16'h0000;
         line_count = 32'h0000_0000;
         expected_events.delete();
      end else begin
         if (req_tvalid && req_tready) predict_events(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) check_event();
      end
      events_outstanding <= expected_events.size();
      mismatch_count     <= errors;
   end

endmodule

### tb/data_file_line_tokenizer_test.sv
`timescale 1ns / 1ps

module data_file_line_tokenizer_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int          events_outstanding;
   int          mismatch_count;
   int          burst_left = 0;
   int          chars_sent = 0;

   always #5 clock = ~clock;

   data_file_line_tokenizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   token_event_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser),
      .rsp_tlast          (rsp_tlast),
      .events_outstanding (events_outstanding),
      .mismatch_count     (mismatch_count)
   );

   // receiver: switch between always ready, coin flip, sparse ready and periodic stalls
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;
   int unsigned tick = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(3);
         stall_left = $urandom_range(400, 50);
      end else begin
         stall_left = stall_left - 1;
      end
      tick = tick + 1;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(1));
         2:       rsp_tready <= ($urandom_range(3) == 0);
         default: rsp_tready <= (tick % 5) != 0;
      endcase
   end

   task automatic send_item(input logic [7:0] ch, input logic eoi);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(40, 1);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= eoi;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_item(8'($urandom_range(255)), 1'b1);
   endtask

   // hold off until every predicted event has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (events_outstanding != 0);
   endtask

   function automatic logic [7:0] pick_char();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) return 8'h61 + 8'($urandom_range(25));
      if (r < 42) return ($urandom_range(1) == 0) ? dflt_pkg::CH_SPACE : dflt_pkg::CH_TAB;
      if (r < 50) return dflt_pkg::CH_SEMI;
      if (r < 56) return dflt_pkg::CH_LBRACE;
      if (r < 60) return dflt_pkg::CH_RBRACE;
      if (r < 66) return dflt_pkg::CH_SLASH;
      if (r < 72) return dflt_pkg::CH_STAR;
      if (r < 75) return dflt_pkg::CH_HASH;
      if (r < 83) return dflt_pkg::CH_COLON;
      if (r < 88) begin
         case ($urandom_range(2))
            0:       return dflt_pkg::CH_VTAB;
            1:       return dflt_pkg::CH_FORMFD;
            default: return dflt_pkg::CH_RETURN;
         endcase
      end
      if (r < 91) return dflt_pkg::CH_NEWLINE;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_letter();
      return 8'h61 + 8'($urandom_range(25));
   endfunction

   task automatic send_random_line();
      int n;
      n = $urandom_range(12);
      case ($urandom_range(9))
         6: begin
            send_item(dflt_pkg::CH_SLASH, 1'b0);
            send_item(dflt_pkg::CH_STAR, 1'b0);
            repeat (n) begin
               case ($urandom_range(3))
                  0:       send_item(dflt_pkg::CH_STAR, 1'b0);
                  1:       send_item(dflt_pkg::CH_NEWLINE, 1'b0);
                  default: send_item(pick_char(), 1'b0);
               endcase
            end
            if ($urandom_range(7) == 0) begin
               send_end();
            end else begin
               send_item(dflt_pkg::CH_STAR, 1'b0);
               send_item(dflt_pkg::CH_SLASH, 1'b0);
            end
         end
         7: begin
            repeat ($urandom_range(4, 1)) send_item(pick_letter(), 1'b0);
            send_item(dflt_pkg::CH_COLON, 1'b0);
            send_item(($urandom_range(1) == 0) ? dflt_pkg::CH_SPACE : pick_char(), 1'b0);
            repeat (n) send_item(pick_char(), 1'b0);
            send_item(dflt_pkg::CH_NEWLINE, 1'b0);
         end
         8: begin
            repeat ($urandom_range(3)) send_item(pick_letter(), 1'b0);
            send_item(dflt_pkg::CH_HASH, 1'b0);
            repeat (n) send_item(8'($urandom_range(255)), 1'b0);
            if ($urandom_range(3) == 0) send_end();
            else send_item(dflt_pkg::CH_NEWLINE, 1'b0);
         end
         9: begin
            // noise and broken input
            if ($urandom_range(1) == 0) send_end();
            else repeat ($urandom_range(6, 1)) send_item(8'($urandom_range(255)), 1'b0);
         end
         default: begin
            repeat (n) send_item(pick_char(), 1'b0);
            if ($urandom_range(15) == 0) send_end();
            else send_item(dflt_pkg::CH_NEWLINE, 1'b0);
         end
      endcase
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme bytes, separators, lookahead, comments, end of input
      send_text("a");
      send_item(8'h00, 1'b0);
      send_text(";{");
      send_item(8'hFF, 1'b0);
      send_text("}/x:\t:q\n/*\n**/#;\nz");
      send_end();
      send_text("#");
      send_end();
      send_text("/*");
      send_end();
      send_text(":");
      send_end();
      drain();

      chars_sent = 0;
      while (chars_sent < 250) send_random_line();
      drain();
      while (chars_sent < 500) send_random_line();
      drain();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && events_outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #30000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
